// ----- src/sspi_pkg.sv -----
// ----------------------------------------------------------------------------
// sspi_pkg: shared types and constants of the steering servo interpolator
// Payload structs, code enums and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package sspi_pkg;

  localparam int AngleBits    = 16;
  localparam int ServoBits    = 16;
  localparam int IndexBits    = 4;
  localparam int CountBits    = 5;
  localparam int CfgIndexBits = 2;
  localparam int MaxPoints    = 16;
  localparam int FracBits     = 16;

  localparam logic [ServoBits-1:0] MidScale = ServoBits'(1) << (ServoBits - 1);

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_ANGLE_MIN   = 2'd0,
    CFG_ANGLE_MAX   = 2'd1,
    CFG_POINT_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                        operation;
    logic [IndexBits-1:0]        point_index;
    logic signed [AngleBits-1:0] angle;
    logic [ServoBits-1:0]        point_servo;
  } in_item_t;

  typedef struct packed {
    logic [ServoBits-1:0] servo_command;
    logic                 map_active;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/sspi_table.sv -----
// ----------------------------------------------------------------------------
// sspi_table: calibration point memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sspi_table #(
  parameter int Depth = 16,
  parameter int Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- src/sspi_divider.sv -----
// ----------------------------------------------------------------------------
// sspi_divider: iterative fraction divider
// Computes (dividend << FracBits) / divisor for dividend <= divisor, one
// quotient bit per cycle with a shared compare and subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module sspi_divider
  import sspi_pkg::*;
#(
  parameter int DataBits = AngleBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [DataBits-1:0] dividend_i,
  input  wire logic [DataBits-1:0] divisor_i,
  output logic                     done_o,
  output logic [FracBits:0]        quotient_o
);

  localparam int Steps    = FracBits + 1;
  localparam int CntBits  = $clog2(Steps + 1);

  logic [DataBits:0]   rem_q, rem_d;
  logic [DataBits-1:0] div_q;
  logic [FracBits:0]   quo_q;
  logic [CntBits-1:0]  cnt_q;
  logic                busy_q, done_q;
  logic                ge;
  logic [DataBits:0]   rem_sub;

  always_comb begin
    ge      = rem_q >= {1'b0, div_q};
    rem_sub = ge ? (rem_q - {1'b0, div_q}) : rem_q;
    // remainder stays below the divisor, so the shift cannot overflow
    rem_d   = {rem_sub[DataBits-1:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(Steps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i};
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[FracBits-1:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- src/steering_servo_interpolator.sv -----
// ----------------------------------------------------------------------------
// steering_servo_interpolator: piecewise linear angle to servo mapping
// Sequencer over the point memory, iterative divider and one multiplier.
// ----------------------------------------------------------------------------
// Write transaction: accepted without producing a result.
// Query: with fewer than two points the result is loaded directly; otherwise the
// first and last points are checked for the table ends, then one segment is
// scanned per step, then the bit-serial divider, multiply, add and output load.
// Input stalls until the result is loaded and is free again in the next cycle.
// Reset clears control and configuration; point memory is undefined until written.
`default_nettype none

module steering_servo_interpolator
  import sspi_pkg::*;
#(
  parameter int MAX_POINTS = MaxPoints
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire in_item_t                in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output out_item_t                    out_data_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [AngleBits-1:0]    cfg_data_i
);

  localparam int IdxW  = $clog2(MAX_POINTS);
  localparam int MemW  = AngleBits + ServoBits;
  localparam int DiffW = ServoBits + 1;
  localparam int ProdW = DiffW + FracBits + 2;

  state_e state_q, state_d;

  logic signed [AngleBits-1:0] min_q, max_q;
  logic [CountBits-1:0]        count_q;

  logic signed [AngleBits-1:0] x_q, prev_a_q;
  logic [ServoBits-1:0]        prev_s_q, last_s_q, s0_q, res_q;
  logic signed [DiffW-1:0]     diff_q;
  logic [FracBits:0]           frac_q;
  logic signed [ProdW-1:0]     prod_q;
  logic [IdxW-1:0]             idx_q, last_idx_q;
  logic                        active_q;

  logic                        out_valid_q;
  out_item_t                   out_q;

  logic                        accept;
  logic                        mem_we;
  logic [IdxW-1:0]             raddr;
  logic [MemW-1:0]             rdata;
  logic signed [AngleBits-1:0] cur_a;
  logic [ServoBits-1:0]        cur_s;
  logic signed [AngleBits-1:0] x_clamp;
  logic signed [AngleBits:0]   seg_d, seg_span;
  logic                        hit;
  logic                        div_start, div_done;
  logic [FracBits:0]           div_quo;
  logic signed [ProdW-1:0]     prod_adj;
  logic                        out_free;
  logic [CountBits-1:0]        count_m1;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign mem_we = accept && (in_data_i.operation == OP_WRITE)
                  && (int'(in_data_i.point_index) < MAX_POINTS);

  assign cur_a = rdata[MemW-1:ServoBits];
  assign cur_s = rdata[ServoBits-1:0];

  // Clamp the query, angle_max last so it wins on inverted limits
  always_comb begin
    x_clamp = in_data_i.angle;
    if (x_clamp < min_q) x_clamp = min_q;
    if (x_clamp > max_q) x_clamp = max_q;
  end

  assign seg_d    = {x_q[AngleBits-1], x_q} - {prev_a_q[AngleBits-1], prev_a_q};
  assign seg_span = {cur_a[AngleBits-1], cur_a} - {prev_a_q[AngleBits-1], prev_a_q};
  assign hit      = (prev_a_q <= x_q) && (x_q <= cur_a);
  assign div_start = (state_q == ST_SCAN) && hit && (seg_span != '0);
  assign count_m1  = count_q - 1'b1;

  // Truncate toward zero: bias negative products before the shift
  assign prod_adj = prod_q + (prod_q[ProdW-1] ? ProdW'((1 << FracBits) - 1) : ProdW'(0));

  sspi_table #(
    .Depth(MAX_POINTS),
    .Width(MemW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(IdxW'(in_data_i.point_index)),
    .wdata_i({in_data_i.angle, in_data_i.point_servo}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  sspi_divider #(
    .DataBits(AngleBits)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(seg_d[AngleBits-1:0]),
    .divisor_i (seg_span[AngleBits-1:0]),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    raddr   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_data_i.operation == OP_QUERY)) begin
          state_d = (count_q < CountBits'(2)) ? ST_OUT : ST_FIRST;
        end
      end
      ST_FIRST: begin
        raddr   = last_idx_q;
        state_d = (x_q <= cur_a) ? ST_OUT : ST_LAST;
      end
      ST_LAST: begin
        raddr   = IdxW'(1);
        state_d = (x_q >= cur_a) ? ST_OUT : ST_SCAN;
      end
      ST_SCAN: begin
        raddr = idx_q + 1'b1;
        if (hit) begin
          state_d = (seg_span != '0) ? ST_DIV : ST_MUL;
        end else if (idx_q == last_idx_q) begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_ADD;
      ST_ADD: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q        <= x_clamp;
        last_idx_q <= IdxW'(count_m1);
        res_q      <= MidScale;
        active_q   <= 1'b0;
      end
      ST_FIRST: begin
        prev_a_q <= cur_a;
        prev_s_q <= cur_s;
        res_q    <= cur_s;
        active_q <= 1'b1;
      end
      ST_LAST: begin
        last_s_q <= cur_s;
        res_q    <= cur_s;
        idx_q    <= IdxW'(1);
      end
      ST_SCAN: begin
        if (hit) begin
          s0_q   <= prev_s_q;
          diff_q <= $signed({1'b0, cur_s}) - $signed({1'b0, prev_s_q});
          frac_q <= '0;
        end else begin
          prev_a_q <= cur_a;
          prev_s_q <= cur_s;
          idx_q    <= idx_q + 1'b1;
          res_q    <= last_s_q;
        end
      end
      ST_DIV: begin
        if (div_done) frac_q <= div_quo;
      end
      ST_MUL: begin
        prod_q <= ProdW'(diff_q) * ProdW'($signed({1'b0, frac_q}));
      end
      ST_ADD: begin
        res_q <= s0_q + prod_adj[FracBits+ServoBits-1:FracBits];
      end
      default: begin
      end
    endcase
  end

  // Output register: load on the final state, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      out_q.servo_command <= res_q;
      out_q.map_active    <= active_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= {1'b1, {(AngleBits-1){1'b0}}};
      max_q   <= {1'b0, {(AngleBits-1){1'b1}}};
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ANGLE_MIN:   min_q <= $signed(cfg_data_i);
        CFG_ANGLE_MAX:   max_q <= $signed(cfg_data_i);
        CFG_POINT_COUNT: begin
          if (int'(cfg_data_i[CountBits-1:0]) > MAX_POINTS) begin
            count_q <= CountBits'(MAX_POINTS);
          end else begin
            count_q <= cfg_data_i[CountBits-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
